>>> sv/z_score_standardizer_top_assert.svh
// Assertion macros for the z-score standardiser top level.
// Depends on nothing; included by z_score_standardizer_top.sv.
`ifndef Z_SCORE_STANDARDIZER_TOP_ASSERT_SVH
`define Z_SCORE_STANDARDIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ZS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ZS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ZS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ZS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/zss_pkg.sv
// Package for the z-score standardiser: sequencer states, unit opcodes, widths.
// Depends on nothing.
package zss_pkg;
  localparam int SumW = 38;
  localparam int SqW  = 53;

  typedef enum logic [3:0] {
    ST_COLLECT, ST_SQUARE, ST_ACC, ST_DIV_MEAN, ST_DIV_EX2, ST_MEAN2, ST_VAR,
    ST_SQRT, ST_READ, ST_DIFF, ST_DIV_RES, ST_EMIT
  } zss_state_t;

  typedef enum logic [1:0] {
    OP_DIV, OP_SQRT, OP_NONE
  } zss_op_t;

  typedef struct packed {
    logic    start;
    zss_op_t op;
  } zss_unit_ctl_t;
endpackage

>>> sv/zss_iter_unit.sv
// Shared iterative unit: restoring divide or bit-pair square root, 64-bit.
// Depends on zss_pkg.
module zss_iter_unit import zss_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  zss_unit_ctl_t ctl,
  input  logic [63:0]   num,
  input  logic [63:0]   den,
  output logic          busy,
  output logic [63:0]   result
);
  logic [63:0] a_r, a_nxt, b_r, b_nxt, q_r, q_nxt, rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  zss_op_t     op_r, op_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] trial;
  logic [63:0] rsh;

  always_comb begin
    a_nxt = a_r; b_nxt = b_r; q_nxt = q_r; rem_nxt = rem_r;
    cnt_nxt = cnt_r; op_nxt = op_r; busy_nxt = busy_r;
    trial = '0; rsh = '0;
    if (ctl.start) begin
      busy_nxt = 1'b1; op_nxt = ctl.op; a_nxt = num; b_nxt = den;
      q_nxt = '0; rem_nxt = '0;
      cnt_nxt = (ctl.op == OP_SQRT) ? 7'd32 : 7'd64;
    end else if (busy_r) begin
      if (op_r == OP_DIV) begin
        rsh = {rem_r[62:0], a_r[63]};
        trial = {1'b0, rsh} - {1'b0, b_r};
        a_nxt = {a_r[62:0], 1'b0};
        if (!trial[64]) begin
          rem_nxt = trial[63:0]; q_nxt = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = rsh; q_nxt = {q_r[62:0], 1'b0};
        end
      end else begin
        rsh = {rem_r[61:0], a_r[63:62]};
        trial = {1'b0, rsh} - {1'b0, q_r[61:0], 2'b01};
        a_nxt = {a_r[61:0], 2'b00};
        if (!trial[64]) begin
          rem_nxt = trial[63:0]; q_nxt = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = rsh; q_nxt = {q_r[62:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; q_r <= q_nxt; rem_r <= rem_nxt;
    cnt_r <= cnt_nxt; op_r <= op_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  assign busy = busy_r;
  assign result = q_r;
endmodule

>>> sv/z_score_standardizer_top.sv
// Top level of the z-score standardiser: sample memory, accumulators, sequencer.
// Depends on zss_pkg, zss_iter_unit and z_score_standardizer_top_assert.svh.
//
// Usage. Requests enter on in_valid/in_stall carrying in_sample (signed Q16.16)
// and in_end_of_column. Each is stored in a MAX_SAMPLES-entry memory and added
// to a running sum and sum of squares; a full memory drops the request and
// flags it. On the request marked end_of_column the block finds the mean and
// E[x^2] with two 64-step divides, the deviation with a 32-step root, then
// emits one result per stored sample in arrival order on out_valid/out_stall,
// each needing one 64-step divide. The last result has out_final_result set.
// A plain sample passes the square and accumulate states, then goes back to collect.
// The closing request waits on the shared divide/root unit for each divide and
// for the root. in_stall stays high throughout.
// A stalled result holds in the output register and the sequencer waits.
// Reset (rst_n low, synchronous) clears the count, sums and flags; memory
// contents are left as they are. A closing request with no stored samples
// still stores its own sample and yields one result.
module z_score_standardizer_top import zss_pkg::*; #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_sample,
  input  logic               in_end_of_column,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_standardized,
  output logic               out_final_result,
  output logic               out_degenerate,
  output logic               out_dropped
);
`include "z_score_standardizer_top_assert.svh"
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  zss_state_t state_r, state_nxt;
  logic [31:0] mem [MAX_SAMPLES];
  logic [31:0] rd_r;
  logic [CW-1:0] count_r, count_nxt, idx_r, idx_nxt;
  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic [SqW-1:0] sq_r, sq_nxt;
  logic ovf_r, ovf_nxt, last_r, last_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] q_r, q_nxt, ex2_r, ex2_nxt, m2_r, m2_nxt, sd_r, sd_nxt;
  logic signed [63:0] var_r, var_nxt;
  logic signed [33:0] diff_r, diff_nxt;
  logic degen_r, degen_nxt, neg_r;
  logic [31:0] res_r, res_nxt;
  logic ovalid_r, ovalid_nxt, ofin_r, ofin_nxt;
  logic sneg_r, sneg_nxt;
  zss_unit_ctl_t ctl;
  logic [63:0] u_num, u_den, u_res;
  logic u_busy;
  logic wr_en;
  logic [63:0] mean_s;
  logic [31:0] mul_a;

  zss_iter_unit u_iter (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .num(u_num), .den(u_den),
    .busy(u_busy), .result(u_res)
  );

  assign in_stall = (state_r != ST_COLLECT) || ovalid_r;
  assign wr_en = in_valid && !in_stall && (count_r < CW'(MAX_SAMPLES));
  assign mean_s = sum_r[SumW-1] ? -q_r : q_r;

  // one shared multiplier: square of a sample or of the mean magnitude
  assign mul_a = (state_r == ST_SQUARE) ? mag_r : q_r[31:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[AW-1:0]] <= in_sample;
    rd_r <= mem[idx_r[AW-1:0]];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: if (in_valid && !in_stall) begin
        state_nxt = wr_en ? ST_SQUARE : (in_end_of_column ? ST_DIV_MEAN : ST_COLLECT);
        if (!wr_en && in_end_of_column && count_r == '0) state_nxt = ST_COLLECT;
      end
      ST_SQUARE:   state_nxt = ST_ACC;
      ST_ACC:      state_nxt = last_r ? ST_DIV_MEAN : ST_COLLECT;
      // advance once the mean is in and the E[x^2] divide is launched
      ST_DIV_MEAN: if (!u_busy && q_r == 64'hFFFF_FFFF_FFFF_FFFF) state_nxt = ST_DIV_EX2;
      ST_DIV_EX2:  if (!u_busy && !ctl.start) state_nxt = ST_MEAN2;
      ST_MEAN2:    state_nxt = ST_VAR;
      ST_VAR:      state_nxt = ST_SQRT;
      ST_SQRT:     if (!u_busy && !ctl.start) state_nxt = ST_READ;
      ST_READ:     state_nxt = ST_DIFF;
      ST_DIFF:     state_nxt = ST_DIV_RES;
      ST_DIV_RES:  if (!u_busy && !ctl.start) state_nxt = ST_EMIT;
      ST_EMIT:     if (!ovalid_r || !out_stall)
        state_nxt = (idx_r + CW'(1) == count_r) ? ST_COLLECT : ST_READ;
      default:     state_nxt = ST_COLLECT;
    endcase
  end

  // datapath and unit control
  always_comb begin
    count_nxt = count_r; idx_nxt = idx_r; sum_nxt = sum_r; sq_nxt = sq_r;
    ovf_nxt = ovf_r; last_nxt = last_r; mag_nxt = mag_r; prod_nxt = prod_r;
    q_nxt = q_r; ex2_nxt = ex2_r; m2_nxt = m2_r; sd_nxt = sd_r; var_nxt = var_r;
    diff_nxt = diff_r; degen_nxt = degen_r; res_nxt = res_r;
    ovalid_nxt = ovalid_r; ofin_nxt = ofin_r; sneg_nxt = sneg_r;
    ctl = '{start: 1'b0, op: OP_NONE};
    u_num = '0; u_den = '0;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    prod_nxt = {32'd0, mul_a} * {32'd0, mul_a};
    case (state_r)
      ST_COLLECT: if (in_valid && !in_stall) begin
        last_nxt = in_end_of_column;
        if (wr_en) begin
          count_nxt = count_r + CW'(1);
          sum_nxt = sum_r + SumW'(in_sample);
          mag_nxt = in_sample[31] ? 32'(-in_sample) : 32'(in_sample);
        end else begin
          ovf_nxt = 1'b1;
          if (in_end_of_column && count_r == '0) begin
            sum_nxt = '0; sq_nxt = '0; ovf_nxt = 1'b0;
          end
        end
      end
      ST_ACC: sq_nxt = sq_r + SqW'(prod_r[63:16]);
      ST_DIV_MEAN: if (!u_busy) begin
        if (q_r != 64'hFFFF_FFFF_FFFF_FFFF && !u_busy && idx_r == '0) begin
          ctl = '{start: 1'b1, op: OP_DIV};
          u_num = 64'(sum_r[SumW-1] ? -sum_r : sum_r);
          u_den = 64'(count_r);
          q_nxt = 64'hFFFF_FFFF_FFFF_FFFF;
        end else begin
          q_nxt = u_res;
          ctl = '{start: 1'b1, op: OP_DIV};
          u_num = 64'(sq_r); u_den = 64'(count_r);
        end
      end
      ST_DIV_EX2: if (!u_busy) ex2_nxt = u_res;
      ST_MEAN2: m2_nxt = prod_r >> 16;
      ST_VAR: begin
        var_nxt = $signed(ex2_r) - $signed(m2_r);
        degen_nxt = var_nxt <= 0;
        ctl = '{start: 1'b1, op: OP_SQRT};
        u_num = {var_nxt[47:0], 16'd0};
      end
      ST_SQRT: if (!u_busy) begin
        sd_nxt = u_res;
        if (u_res == '0) degen_nxt = 1'b1;
      end
      ST_DIFF: begin
        diff_nxt = 34'($signed(rd_r)) - 34'($signed(mean_s));
        sneg_nxt = diff_nxt[33];
        ctl = '{start: 1'b1, op: OP_DIV};
        u_num = {14'd0, (diff_nxt[33] ? 34'(-diff_nxt) : diff_nxt), 16'd0};
        u_den = degen_r ? 64'd1 : sd_r;
      end
      ST_EMIT: if (!ovalid_r || !out_stall) begin
        ovalid_nxt = 1'b1;
        ofin_nxt = (idx_r + CW'(1) == count_r);
        if (degen_r) res_nxt = '0;
        else if (sneg_r) res_nxt = (u_res > 64'h8000_0000) ? 32'h8000_0000 : 32'(-u_res);
        else res_nxt = (u_res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : u_res[31:0];
        idx_nxt = idx_r + CW'(1);
        if (ofin_nxt) begin
          idx_nxt = '0; count_nxt = '0; sum_nxt = '0; sq_nxt = '0;
          q_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt; prod_r <= prod_nxt; ex2_r <= ex2_nxt;
    m2_r <= m2_nxt; sd_r <= sd_nxt; var_r <= var_nxt; diff_r <= diff_nxt;
    res_r <= res_nxt; last_r <= last_nxt; sneg_r <= sneg_nxt;
    neg_r <= degen_r;
    if (!rst_n) begin
      state_r <= ST_COLLECT; count_r <= '0; idx_r <= '0; sum_r <= '0;
      sq_r <= '0; ovf_r <= 1'b0; ovalid_r <= 1'b0; ofin_r <= 1'b0;
      degen_r <= 1'b0; q_r <= '0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; idx_r <= idx_nxt;
      sum_r <= sum_nxt; sq_r <= sq_nxt; ovalid_r <= ovalid_nxt;
      ofin_r <= ofin_nxt; degen_r <= degen_nxt; q_r <= q_nxt;
      // drop the overflow mark once the final result is handed over
      if (ovalid_r && !out_stall && ofin_r) ovf_r <= 1'b0;
      else ovf_r <= ovf_nxt;
    end
  end

  logic out_dropped_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_dropped_r <= 1'b0;
    else if (state_r == ST_EMIT && (!ovalid_r || !out_stall)) out_dropped_r <= ovf_r;
  end

  assign out_valid = ovalid_r;
  assign out_standardized = res_r;
  assign out_final_result = ofin_r;
  assign out_degenerate = neg_r;
  assign out_dropped = out_dropped_r;

  `ZS_ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, count_r <= CW'(MAX_SAMPLES))
  `ZS_ASSERT_IMPL(a_no_in_busy, clk, rst_n, state_r != ST_COLLECT, in_stall)
  `ZS_ASSERT_NEXT(a_fin_clears, clk, rst_n, ovalid_r && !out_stall && ofin_r, count_r == '0)
endmodule
